### rtl/core/bdeq_pkg.sv
// shared types and codes for the bounded double-ended queue
package bdeq_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // request codes
  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } ctl_t;

endpackage

### rtl/core/bounded_double_ended_queue_unit.sv
// top level of the bounded double-ended queue
// a request transferred while idle is executed in the exec state and its result is strobed in the done state
// the sequencer takes one request at a time (latch, ram access, respond) and holds busy until back in idle
// the result is shown for one cycle on done_o and the receiver cannot stall it
// reset: asynchronous active-low rst_ni empties the queue (head and count to zero);
// the entry ram is not cleared, only written slots are ever read
module bounded_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                start,
  output logic                                busy,
  input  logic [bdeq_pkg::FuncW-1:0]          func_i,
  input  logic signed [bdeq_pkg::ValueW-1:0]  value_i,
  // result side
  output logic                                done_o,
  output logic [bdeq_pkg::StatusW-1:0]        status_o,
  output logic signed [bdeq_pkg::ValueW-1:0]  popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy_o
);
  import bdeq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  ctl_t              ctl;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;

  // sequencer: one transfer in, one result strobe out
  bdeq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  // ring pointers and result formation
  bdeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .func_i         (func_i),
    .value_i        (value_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .occupancy_o    (occupancy_o)
  );

  // entry storage, read data registered and held until the next pop
  bdeq_ram #(
    .Width (ValueW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result strobe lasts exactly the respond cycle
  assign done_o = ctl.respond;

endmodule

### rtl/core/bdeq_ram.sv
// generic single-write, single-read ram with registered read data
module bdeq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bdeq_ctrl.sv
// request sequencer: idle, execute, respond
module bdeq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output bdeq_pkg::ctl_t  ctl_o
);
  import bdeq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        ctl_o.load = start;
      end
      ST_EXEC: ctl_o.exec    = 1'b1;
      ST_DONE: ctl_o.respond = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

### rtl/core/bdeq_dpath.sv
// ring pointers, occupancy, request registers and result formation
module bdeq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdeq_pkg::ctl_t                      ctl_i,
  input  logic [bdeq_pkg::FuncW-1:0]          func_i,
  input  logic signed [bdeq_pkg::ValueW-1:0]  value_i,
  // ram side
  output logic                                ram_we_o,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr_o,
  output logic [bdeq_pkg::ValueW-1:0]         ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr_o,
  input  logic [bdeq_pkg::ValueW-1:0]         ram_rdata_i,
  // result
  output logic [bdeq_pkg::StatusW-1:0]        status_o,
  output logic signed [bdeq_pkg::ValueW-1:0]  popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy_o
);
  import bdeq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  func_e               func_q;
  logic [ValueW-1:0]   value_q;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic                pop_ok_q, pop_ok_d;

  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc, tail_slot, last_slot;
  logic [SW-1:0] tail_sum;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // ring arithmetic modulo DEPTH
  assign head_dec  = (head_q == '0) ? LastSlot : head_q - AW'(1);
  assign head_inc  = (head_q == LastSlot) ? '0 : head_q + AW'(1);
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign last_slot = (tail_slot == '0) ? LastSlot : tail_slot - AW'(1);

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    status_d    = status_q;
    pop_ok_d    = pop_ok_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail_slot;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;
    if (ctl_i.exec) begin
      status_d = STATUS_OK;
      pop_ok_d = 1'b0;
      case (func_q)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = head_dec;
            head_d      = head_dec;
            count_d     = count_q + CW'(1);
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = tail_slot;
            count_d     = count_q + CW'(1);
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = head_q;
            head_d      = head_inc;
            count_d     = count_q - CW'(1);
            pop_ok_d    = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = last_slot;
            count_d     = count_q - CW'(1);
            pop_ok_d    = 1'b1;
          end
        end
      endcase
    end
  end

  assign ram_wdata_o = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= STATUS_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q  <= func_e'(func_i);
      value_q <= value_i;
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? $signed(ram_rdata_i) : '0;
  assign occupancy_o    = count_q;

endmodule

### tb/tb_bounded_double_ended_queue_unit.sv
// self-checking testbench for the bounded double-ended queue unit
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue_unit;
  import bdeq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IdxW       = $clog2(DEPTH);
  localparam int unsigned OccW       = $clog2(DEPTH + 1);
  localparam int unsigned RandItems  = 930;
  localparam int unsigned CycleLimit = 100000;

  // one expected result, in the order requests were transferred
  typedef struct {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] popped;
    logic [OccW-1:0]          occupancy;
  } outcome_t;

  // mirror of the ring plus the list of results still owed by the block
  class deque_tracker;
    logic [ValueW-1:0] mirror_slots [DEPTH];
    logic [IdxW-1:0]   mirror_head;
    logic [OccW-1:0]   mirror_fill;
    outcome_t          awaited_results [$];
    int unsigned       error_count;

    function new();
      mirror_head = '0;
      mirror_fill = '0;
      error_count = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
    endtask

    // apply one transferred request to the mirror and queue its outcome
    function void note_request(input func_e f, input logic signed [ValueW-1:0] v);
      outcome_t        o;
      logic [IdxW-1:0] slot;
      o.status = STATUS_OK;
      o.popped = '0;
      case (f)
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (mirror_fill == DEPTH) begin
            o.status = STATUS_FULL;
          end else begin
            if (f == FUNC_PUSH_FRONT) begin
              mirror_head = mirror_head - 1'b1;
              slot = mirror_head;
            end else begin
              slot = mirror_head + mirror_fill[IdxW-1:0];
            end
            mirror_slots[slot] = v;
            mirror_fill++;
          end
        end
        default: begin
          if (mirror_fill == 0) begin
            o.status = STATUS_EMPTY;
          end else begin
            if (f == FUNC_POP_FRONT) begin
              slot = mirror_head;
              mirror_head = mirror_head + 1'b1;
            end else begin
              // a full ring has fill[IdxW-1:0] == 0, so this wraps to head - 1
              slot = mirror_head + mirror_fill[IdxW-1:0] - 1'b1;
            end
            o.popped = mirror_slots[slot];
            mirror_fill--;
          end
        end
      endcase
      o.occupancy = mirror_fill;
      awaited_results.push_back(o);
    endfunction

    task check_result(input logic [StatusW-1:0] status, input logic signed [ValueW-1:0] popped,
                      input logic [OccW-1:0] occupancy);
      outcome_t o;
      if (awaited_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        o = awaited_results.pop_front();
        if (status !== o.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, o.status));
        if (popped !== o.popped)
          report_mismatch($sformatf("popped value %0d, expected %0d", popped, o.popped));
        if (occupancy !== o.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, o.occupancy));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [FuncW-1:0]         func_i;
  logic signed [ValueW-1:0] value_i;
  logic                     done_o;
  logic [StatusW-1:0]       status_o;
  logic signed [ValueW-1:0] popped_value_o;
  logic [OccW-1:0]          occupancy_o;

  int unsigned  cycle_count = 0;
  deque_tracker tracker;

  bounded_double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .occupancy_o   (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // free-running cycle count, used only for the timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("** bounded_double_ended_queue_unit: FAILED **");
    $finish;
  end

  // results last one cycle and cannot be stalled: take each one at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_result(status_o, popped_value_o, occupancy_o);
    end
  end

  // present a request and hold it until the edge that transfers it;
  // start is left high so a following request goes out back to back
  task automatic send_request(input func_e f, input logic signed [ValueW-1:0] v);
    start   <= 1'b1;
    func_i  <= f;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    tracker.note_request(f, v);
  endtask

  // drop start between bursts
  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned              burst_left;
    int unsigned              segment_left;
    int unsigned              push_weight;
    func_e                    f;
    logic signed [ValueW-1:0] v;

    tracker = new();
    start   <= 1'b0;
    func_i  <= FUNC_PUSH_FRONT;
    value_i <= '0;
    rst_ni  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // pops on an empty queue are refused
    send_request(FUNC_POP_FRONT, 32'sh1234_5678);
    send_request(FUNC_POP_BACK, 32'sh7FFF_FFFF);
    // extremes in and out through each end
    send_request(FUNC_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(FUNC_PUSH_FRONT, 32'sh8000_0000);
    send_request(FUNC_POP_BACK, '0);
    send_request(FUNC_POP_FRONT, '0);
    // fill to capacity from both ends; the first front push wraps head below zero
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: v = 32'sh0000_0000;
        1: v = 32'shFFFF_FFFF;
        2: v = (i % 8 == 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA;
        default: v = (i % 8 == 3) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
      send_request((i % 2 == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, v);
    end
    // pushes on a full queue are refused at either end
    send_request(FUNC_PUSH_FRONT, 32'sh0BAD_F00D);
    send_request(FUNC_PUSH_BACK, 32'shFFFF_FFFF);

    // random part: segments with a push bias drift between empty and full,
    // so both refusals and ring wraps keep coming up
    burst_left   = 0;
    segment_left = 0;
    push_weight  = 50;
    for (int n = 0; n < RandItems; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        push_weight  = $urandom_range(10, 90);
      end
      segment_left--;

      // sender bursts, with some gap-free stretches
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;

      if ($urandom_range(0, 99) < push_weight)
        f = ($urandom_range(0, 1) == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      else
        f = ($urandom_range(0, 1) == 0) ? FUNC_POP_FRONT : FUNC_POP_BACK;

      case ($urandom_range(0, 11))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = '0;
        3: v = '1;
        default: v = $urandom();
      endcase
      send_request(f, v);
    end
    start <= 1'b0;

    // let the last results drain, then allow the pipeline latency once more
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (tracker.error_count == 0) begin
      $display("** bounded_double_ended_queue_unit: PASSED **");
    end else begin
      $display("** bounded_double_ended_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
